[rtl/core/append_log_segment_table_core_assert.svh]
// Assertion macros for the segment table RTL.
// Used by alst_back.sv under rtl/core; depends on clk_i and rst_ni in scope.
`ifndef APPEND_LOG_SEGMENT_TABLE_CORE_ASSERT_SVH
`define APPEND_LOG_SEGMENT_TABLE_CORE_ASSERT_SVH

// Plain property, checked on every clock edge outside reset
`define ALST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when ante holds, cons holds in the same cycle
`define ALST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/alst_pkg.sv]
// Shared types and constants of the append-log segment table.
// No dependencies; used by alst_front, alst_back and the top level.
package alst_pkg;

  localparam int SEGMENTS   = 16;
  localparam int SEG_W      = $clog2(SEGMENTS);
  localparam int CNT_W      = SEG_W + 1;
  localparam int MAX_RES    = 16;
  localparam int RES_W      = $clog2(MAX_RES + 1);
  localparam int IDX_W      = (RES_W > CNT_W) ? RES_W : CNT_W;
  localparam int SPAN_SHIFT = 4;
  localparam logic [62:0] MAX_BLK_RESET = 63'd2147483647;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TRIM   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ABSENT = 3'd1,
    ST_BADPOS = 3'd2,
    ST_FULL   = 3'd3,
    ST_ZERO   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_LOOK,
    SQ_TRIM,
    SQ_EMIT
  } seq_e;

  // Classified item passed from front to back
  typedef struct packed {
    func_e       func;
    logic [63:0] blk;
    logic [31:0] cnt;
    logic        cnt_zero;
  } cmd_t;

  // One result item
  typedef struct packed {
    status_e     status;
    logic [63:0] segment_start;
    logic [63:0] offset_in_segment;
    logic        new_segment;
    logic        removed;
    logic [63:0] first_block;
    logic [63:0] next_block;
    logic        last;
  } res_t;

endpackage

[rtl/core/append_log_segment_table_core.sv]
// Segment table of an append-only block log: lookup, append and trim.
// Append, unused codes and lookups outside the held range go from EXEC to the result
// register; a lookup walks the segments in LOOK; a trim drops in TRIM, then emits in EMIT.
// The back end takes one item at a time; it pops the next only once it is back in IDLE.
// Reset: table empty, block numbers zero, size limit 2147483647; no clearing pass.
module append_log_segment_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] block_number_i,
  input  logic [31:0] block_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [63:0] segment_start_o,
  output logic [63:0] offset_in_segment_o,
  output logic        new_segment_o,
  output logic        removed_o,
  output logic [63:0] first_block_o,
  output logic [63:0] next_block_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [62:0] cfg_data_i
);

  alst_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_pop;
  alst_pkg::res_t res;
  logic [62:0]    max_blk_q;

  // size limit register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_blk_q <= alst_pkg::MAX_BLK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_blk_q <= cfg_data_i;
    end
  end

  alst_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .block_number_i (block_number_i),
    .block_count_i  (block_count_i),
    .cmd_o          (cmd),
    .cmd_valid_o    (cmd_valid),
    .cmd_pop_i      (cmd_pop)
  );

  alst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .max_blk_i   (max_blk_q),
    .res_o       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  assign status_o            = res.status;
  assign segment_start_o     = res.segment_start;
  assign offset_in_segment_o = res.offset_in_segment;
  assign new_segment_o       = res.new_segment;
  assign removed_o           = res.removed;
  assign first_block_o       = res.first_block;
  assign next_block_o        = res.next_block;
  assign last_o              = res.last;

endmodule

[rtl/core/alst_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on alst_pkg.
module alst_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [63:0]        block_number_i,
  input  logic [31:0]        block_count_i,
  output alst_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o,
  input  logic               cmd_pop_i
);

  alst_pkg::cmd_t q_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     fill_q, fill_d;
  logic           push, pop;
  alst_pkg::cmd_t entry;

  // classify incoming item
  always_comb begin
    entry.func     = alst_pkg::func_e'(func_i);
    entry.blk      = block_number_i;
    entry.cnt      = block_count_i;
    entry.cnt_zero = (block_count_i == 32'd0);
  end

  assign in_stall_o  = (fill_q == 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = q_q[rd_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  // two-entry queue pointers
  always_comb begin
    wr_d   = push ? ~wr_q : wr_q;
    rd_d   = pop ? ~rd_q : rd_q;
    fill_d = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= entry;
    end
  end

endmodule

[rtl/core/alst_back.sv]
// Back end: segment table, sequencer for lookup/append/trim, result register.
// Depends on alst_pkg and append_log_segment_table_core_assert.svh.
`include "append_log_segment_table_core_assert.svh"
module alst_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alst_pkg::cmd_t     cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  input  logic [62:0]        max_blk_i,
  output alst_pkg::res_t     res_o,
  output logic               out_valid_o,
  input  logic               out_stall_i
);

  localparam int SW = alst_pkg::SEG_W;
  localparam int CW = alst_pkg::CNT_W;
  localparam int IW = alst_pkg::IDX_W;
  localparam int RW = alst_pkg::RES_W;

  // segment store; reads are combinational and see the content before a write in that cycle
  logic [63:0] start_q [alst_pkg::SEGMENTS];
  logic [63:0] len_q   [alst_pkg::SEGMENTS];

  alst_pkg::seq_e state_q, state_d;
  alst_pkg::cmd_t cmd_q, cmd_d;
  logic [SW-1:0]  head_q, head_d, base_q, base_d;
  logic [CW-1:0]  count_q, count_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic [RW-1:0]  ndrop_q, ndrop_d;
  logic [63:0]    first_q, first_d, next_q, next_d;
  alst_pkg::res_t out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic           advance, emit;
  logic [SW-1:0]  rd_addr, wr_addr;
  logic [63:0]    rd_start, rd_len, wr_start, wr_len;
  logic           wr_start_en, wr_len_en;
  logic [64:0]    app_sum;
  logic [63:0]    span, seg_end, lk_diff;
  logic [64:0]    grow;
  logic           fresh, hit, last_res;

  assign advance     = !out_valid_q || !out_stall_i;
  assign cmd_pop_o   = (state_q == alst_pkg::SQ_IDLE) && cmd_valid_i;
  assign res_o       = out_q;
  assign out_valid_o = out_valid_q;

  // single read port, address chosen by sequencer state
  always_comb begin
    unique case (state_q)
      alst_pkg::SQ_EXEC: rd_addr = head_q + count_q[SW-1:0] - SW'(1);
      alst_pkg::SQ_LOOK: rd_addr = head_q + idx_q[SW-1:0];
      alst_pkg::SQ_EMIT: rd_addr = base_q + idx_q[SW-1:0];
      default:           rd_addr = head_q;
    endcase
  end
  assign rd_start = start_q[rd_addr];
  assign rd_len   = len_q[rd_addr];

  // datapath terms
  assign app_sum = {1'b0, next_q} + {33'd0, cmd_q.cnt};
  assign span    = next_q - first_q;
  assign grow    = {1'b0, rd_len} + {33'd0, cmd_q.cnt};
  assign fresh   = (count_q == '0) || (rd_len > (span >> alst_pkg::SPAN_SHIFT)) ||
                   (grow > {2'b00, max_blk_i});
  assign seg_end = rd_start + rd_len;
  assign lk_diff = cmd_q.blk - rd_start;
  assign hit     = (lk_diff < rd_len) && (cmd_q.blk >= rd_start);
  assign last_res = ((idx_q + IW'(1)) == IW'(ndrop_q));

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    head_d      = head_q;
    base_d      = base_q;
    count_d     = count_q;
    idx_d       = idx_q;
    ndrop_d     = ndrop_q;
    first_d     = first_q;
    next_d      = next_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    emit        = 1'b0;
    wr_addr     = head_q + count_q[SW-1:0];
    wr_start    = cmd_q.blk;
    wr_len      = {32'd0, cmd_q.cnt};
    wr_start_en = 1'b0;
    wr_len_en   = 1'b0;
    out_d.status            = alst_pkg::ST_OK;
    out_d.segment_start     = '0;
    out_d.offset_in_segment = '0;
    out_d.new_segment       = 1'b0;
    out_d.removed           = 1'b0;
    out_d.last              = 1'b1;

    unique case (state_q)
      alst_pkg::SQ_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          state_d = alst_pkg::SQ_EXEC;
        end
      end
      alst_pkg::SQ_EXEC: begin
        if (advance) begin
          unique case (cmd_q.func)
            alst_pkg::FUNC_LOOKUP: begin
              if (cmd_q.blk >= first_q && cmd_q.blk < next_q && count_q != '0) begin
                idx_d   = '0;
                state_d = alst_pkg::SQ_LOOK;
              end else begin
                out_d.status = alst_pkg::ST_ABSENT;
                emit         = 1'b1;
              end
            end
            alst_pkg::FUNC_APPEND: begin
              emit = 1'b1;
              if (cmd_q.cnt_zero) begin
                out_d.status = alst_pkg::ST_ZERO;
              end else if (cmd_q.blk != next_q || app_sum[64]) begin
                out_d.status = alst_pkg::ST_BADPOS;
              end else if (fresh && count_q == CW'(alst_pkg::SEGMENTS)) begin
                out_d.status = alst_pkg::ST_FULL;
              end else if (fresh) begin
                wr_start_en         = 1'b1;
                wr_len_en           = 1'b1;
                count_d             = count_q + CW'(1);
                next_d              = app_sum[63:0];
                out_d.segment_start = cmd_q.blk;
                out_d.new_segment   = 1'b1;
              end else begin
                wr_addr             = rd_addr;
                wr_len              = grow[63:0];
                wr_len_en           = 1'b1;
                next_d              = app_sum[63:0];
                out_d.segment_start = rd_start;
              end
            end
            alst_pkg::FUNC_TRIM: begin
              idx_d   = '0;
              ndrop_d = '0;
              base_d  = head_q;
              state_d = alst_pkg::SQ_TRIM;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
          if (emit) begin
            state_d = alst_pkg::SQ_IDLE;
          end
        end
      end
      alst_pkg::SQ_LOOK: begin
        if (advance) begin
          if (hit) begin
            out_d.segment_start     = rd_start;
            out_d.offset_in_segment = lk_diff;
            emit                    = 1'b1;
            state_d                 = alst_pkg::SQ_IDLE;
          end else if ((idx_q + IW'(1)) >= IW'(count_q)) begin
            out_d.status = alst_pkg::ST_ABSENT;
            emit         = 1'b1;
            state_d      = alst_pkg::SQ_IDLE;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      alst_pkg::SQ_TRIM: begin
        // segments are contiguous, so the next head starts at this end
        if (ndrop_q < RW'(alst_pkg::MAX_RES) && count_q >= CW'(2) &&
            seg_end <= cmd_q.blk) begin
          head_d  = head_q + SW'(1);
          count_d = count_q - CW'(1);
          first_d = seg_end;
          ndrop_d = ndrop_q + RW'(1);
        end else begin
          idx_d   = '0;
          state_d = alst_pkg::SQ_EMIT;
        end
      end
      alst_pkg::SQ_EMIT: begin
        if (advance) begin
          emit = 1'b1;
          if (ndrop_q == '0) begin
            state_d = alst_pkg::SQ_IDLE;
          end else begin
            out_d.segment_start = rd_start;
            out_d.removed       = 1'b1;
            out_d.last          = last_res;
            idx_d               = idx_q + IW'(1);
            if (last_res) begin
              state_d = alst_pkg::SQ_IDLE;
            end
          end
        end
      end
      default: state_d = alst_pkg::SQ_IDLE;
    endcase

    if (emit) begin
      out_d.first_block = first_d;
      out_d.next_block  = next_d;
      out_valid_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alst_pkg::SQ_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      first_q     <= '0;
      next_q      <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      ndrop_q     <= '0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      first_q     <= first_d;
      next_q      <= next_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      ndrop_q     <= ndrop_d;
      base_q      <= base_d;
    end
  end

  // payload registers and store writes; the result holds until replaced
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (emit) begin
      out_q <= out_d;
    end
    if (wr_start_en) begin
      start_q[wr_addr] <= wr_start;
    end
    if (wr_len_en) begin
      len_q[wr_addr] <= wr_len;
    end
  end

  `ALST_ASSERT(a_count_bound, count_q <= CW'(alst_pkg::SEGMENTS), "segment count overflow")
  `ALST_ASSERT_IMP(a_look_nonempty, state_q == alst_pkg::SQ_LOOK, count_q != '0, "walk on empty table")
  `ALST_ASSERT_IMP(a_removed_ok, out_valid_q && out_q.removed, out_q.status == alst_pkg::ST_OK, "bad trim status")

endmodule

[sim/append_log_segment_table_core_tb.sv]
// Testbench for append_log_segment_table_core: lookup, append and trim on the segment ring.
// Depends on alst_pkg and the core RTL; results are checked against an in-bench table model.
`timescale 1ns / 1ps

module append_log_segment_table_core_tb;

  localparam int N_SEG = 16;
  localparam int MAX_DROPS = 16;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [63:0] block_number_i;
  logic [31:0] block_count_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [63:0] segment_start_o;
  logic [63:0] offset_in_segment_o;
  logic        new_segment_o;
  logic        removed_o;
  logic [63:0] first_block_o;
  logic [63:0] next_block_o;
  logic        last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [62:0] cfg_data_i;

  append_log_segment_table_core u_dut (.*);

  // table model
  logic [63:0] mdl_start [N_SEG];
  logic [63:0] mdl_len [N_SEG];
  int unsigned mdl_head;
  int unsigned mdl_count;
  logic [63:0] mdl_first;
  logic [63:0] mdl_next;
  logic [62:0] mdl_max_blk;

  alst_pkg::res_t expected_results[$];
  int   error_count;
  int   send_idle_pct;
  int   stall_pct;
  bit   hold_off;
  longint unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic alst_pkg::res_t mk_res(alst_pkg::status_e st, logic [63:0] seg,
                                            logic [63:0] offs, logic nseg, logic rem);
    alst_pkg::res_t r;
    r.status = st;
    r.segment_start = seg;
    r.offset_in_segment = offs;
    r.new_segment = nseg;
    r.removed = rem;
    r.first_block = mdl_first;
    r.next_block = mdl_next;
    r.last = 1'b0;
    return r;
  endfunction

  // compute the results of one item and queue them
  function automatic void predict_table_op(alst_pkg::func_e fn, logic [63:0] blk,
                                           logic [31:0] cnt);
    alst_pkg::res_t rs[$];
    logic [63:0] drops[$];
    logic [63:0] nxt;
    logic [64:0] sum;
    int unsigned s;
    bit fresh;
    bit hit;
    hit = 1'b0;
    case (fn)
      alst_pkg::FUNC_LOOKUP: begin
        if (blk >= mdl_first && blk < mdl_next) begin
          for (int i = 0; i < mdl_count; i++) begin
            s = (mdl_head + i) % N_SEG;
            if (!hit && blk >= mdl_start[s] && blk - mdl_start[s] < mdl_len[s]) begin
              rs.push_back(mk_res(alst_pkg::ST_OK, mdl_start[s], blk - mdl_start[s], 0, 0));
              hit = 1'b1;
            end
          end
        end
        if (!hit) rs.push_back(mk_res(alst_pkg::ST_ABSENT, 0, 0, 0, 0));
      end
      alst_pkg::FUNC_APPEND: begin
        nxt = mdl_next + {32'd0, cnt};
        if (cnt == 0) begin
          rs.push_back(mk_res(alst_pkg::ST_ZERO, 0, 0, 0, 0));
        end else if (blk != mdl_next || nxt < mdl_next) begin
          rs.push_back(mk_res(alst_pkg::ST_BADPOS, 0, 0, 0, 0));
        end else begin
          if (mdl_count == 0) begin
            fresh = 1'b1;
          end else begin
            s = (mdl_head + mdl_count - 1) % N_SEG;
            sum = {1'b0, mdl_len[s]} + {33'd0, cnt};
            fresh = (mdl_len[s] > ((mdl_next - mdl_first) >> 4)) ||
                    (sum > {2'b0, mdl_max_blk});
          end
          if (fresh && mdl_count >= N_SEG) begin
            rs.push_back(mk_res(alst_pkg::ST_FULL, 0, 0, 0, 0));
          end else begin
            if (fresh) begin
              s = (mdl_head + mdl_count) % N_SEG;
              mdl_start[s] = blk;
              mdl_len[s] = 0;
              mdl_count++;
            end else begin
              s = (mdl_head + mdl_count - 1) % N_SEG;
            end
            mdl_len[s] += {32'd0, cnt};
            mdl_next = nxt;
            rs.push_back(mk_res(alst_pkg::ST_OK, mdl_start[s], 0, fresh, 0));
          end
        end
      end
      alst_pkg::FUNC_TRIM: begin
        while (drops.size() < MAX_DROPS && mdl_count >= 2 &&
               mdl_start[mdl_head] + mdl_len[mdl_head] <= blk) begin
          drops.push_back(mdl_start[mdl_head]);
          mdl_head = (mdl_head + 1) % N_SEG;
          mdl_count--;
          mdl_first = mdl_start[mdl_head];
        end
        if (drops.size() == 0) rs.push_back(mk_res(alst_pkg::ST_OK, 0, 0, 0, 0));
        foreach (drops[k]) rs.push_back(mk_res(alst_pkg::ST_OK, drops[k], 0, 0, 1));
      end
      default: rs.push_back(mk_res(alst_pkg::ST_OK, 0, 0, 0, 0));
    endcase
    rs[rs.size() - 1].last = 1'b1;
    foreach (rs[k]) expected_results.push_back(rs[k]);
  endfunction

  // send one item; prediction happens at acceptance, valid stays up for a follow-on item
  task automatic send_item(alst_pkg::func_e fn, logic [63:0] blk, logic [31:0] cnt);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    block_number_i <= blk;
    block_count_i <= cnt;
    do @(posedge clk_i); while (in_stall_o);
    predict_table_op(fn, blk, cnt);
  endtask

  // receiver stall generation
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    alst_pkg::res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item, status %0d", status_o);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); error_count++;
        end
        if (segment_start_o !== e.segment_start) begin
          $error("segment_start exp %0h got %0h", e.segment_start, segment_start_o);
          error_count++;
        end
        if (offset_in_segment_o !== e.offset_in_segment) begin
          $error("offset_in_segment exp %0h got %0h", e.offset_in_segment,
                 offset_in_segment_o);
          error_count++;
        end
        if (new_segment_o !== e.new_segment) begin
          $error("new_segment exp %0b got %0b", e.new_segment, new_segment_o); error_count++;
        end
        if (removed_o !== e.removed) begin
          $error("removed exp %0b got %0b", e.removed, removed_o); error_count++;
        end
        if (first_block_o !== e.first_block) begin
          $error("first_block exp %0h got %0h", e.first_block, first_block_o); error_count++;
        end
        if (next_block_o !== e.next_block) begin
          $error("next_block exp %0h got %0h", e.next_block, next_block_o); error_count++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0b got %0b", e.last, last_o); error_count++;
        end
      end
    end
  end

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_max_blocks(logic [62:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mdl_max_blk = val;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] held_block();
    if (mdl_next == mdl_first) return mdl_next;
    return mdl_first + (rand64() % (mdl_next - mdl_first));
  endfunction

  // random mix, mostly valid appends and lookups, plus trims and broken items
  task automatic run_random_mix(int n_items, int max_cnt);
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 40)
        send_item(alst_pkg::FUNC_APPEND, mdl_next, $urandom_range(max_cnt, 1));
      else if (pick < 65)
        send_item(alst_pkg::FUNC_LOOKUP, ($urandom_range(3) == 0) ? rand64() : held_block(),
                  $urandom());
      else if (pick < 80)
        send_item(alst_pkg::FUNC_TRIM, held_block() + $urandom_range(8), $urandom());
      else if (pick < 85)
        send_item(alst_pkg::FUNC_APPEND, mdl_next, 32'd0);
      else if (pick < 90)
        send_item(alst_pkg::FUNC_APPEND, rand64(), $urandom());
      else if (pick < 95)
        send_item(alst_pkg::FUNC_TRIM, rand64(), $urandom());
      else
        send_item(alst_pkg::FUNC_NOP, rand64(), $urandom());
    end
  endtask

  // corner cases on a fresh table
  task automatic test_directed();
    send_item(alst_pkg::FUNC_LOOKUP, 64'd0, 32'd0);
    send_item(alst_pkg::FUNC_TRIM, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(alst_pkg::FUNC_APPEND, 64'd5, 32'd3);
    send_item(alst_pkg::FUNC_APPEND, 64'd0, 32'd0);
    send_item(alst_pkg::FUNC_APPEND, 64'd0, 32'hFFFF_FFFF);
    send_item(alst_pkg::FUNC_APPEND, mdl_next, 32'd1);
    send_item(alst_pkg::FUNC_APPEND, mdl_next, 32'd100);
    send_item(alst_pkg::FUNC_LOOKUP, 64'd0, 32'd0);
    send_item(alst_pkg::FUNC_LOOKUP, 64'd1_000_000, 32'd0);
    send_item(alst_pkg::FUNC_LOOKUP, mdl_next - 1, 32'd0);
    send_item(alst_pkg::FUNC_LOOKUP, mdl_next, 32'd0);
    send_item(alst_pkg::FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(alst_pkg::FUNC_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(alst_pkg::FUNC_TRIM, 64'd0, 32'd0);
    send_item(alst_pkg::FUNC_TRIM, mdl_next, 32'd0);
    send_item(alst_pkg::FUNC_LOOKUP, mdl_first - 1, 32'd0);
  endtask

  // zero size limit: every append opens a segment until the table fills
  task automatic test_table_full();
    write_max_blocks(63'd0);
    for (int i = 0; i < 18; i++)
      send_item(alst_pkg::FUNC_APPEND, mdl_next, $urandom_range(5, 1));
    send_item(alst_pkg::FUNC_LOOKUP, held_block(), 32'd0);
    send_item(alst_pkg::FUNC_TRIM, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
  endtask

  // appends of 0xFFFFFFFF blocks raise the next block number to at least 2^36, trimming when full
  task automatic test_number_space_end();
    write_max_blocks(63'h7FFF_FFFF_FFFF_FFFF);
    while (mdl_next < 64'hFFFF_FFFF_0000_0000) begin
      send_item(alst_pkg::FUNC_APPEND, mdl_next, 32'hFFFF_FFFF);
      if (mdl_next < 64'h0000_0100_0000_0000 && mdl_count == N_SEG)
        send_item(alst_pkg::FUNC_TRIM, mdl_next, 32'd0);
      if (mdl_next >= 64'h0000_0010_0000_0000) break;
    end
    send_item(alst_pkg::FUNC_APPEND, mdl_next, 32'hFFFF_FFFF);
    send_item(alst_pkg::FUNC_LOOKUP, held_block(), 32'd0);
  endtask

  // receiver holds off long while items keep coming
  task automatic test_back_pressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      run_random_mix(20, 40);
    join
  endtask

  task automatic test_random_phases();
    write_max_blocks(63'd1);
    run_random_mix(30, 4);
    write_max_blocks(63'd64);
    send_idle_pct = 51;
    run_random_mix(45, 20);
    write_max_blocks(63'd2147483647);
    send_idle_pct = 0;
    stall_pct = 51;
    run_random_mix(45, 1000);
    write_max_blocks(63'd300);
    send_idle_pct = 35;
    stall_pct = 35;
    run_random_mix(45, 100);
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = alst_pkg::FUNC_LOOKUP;
    block_number_i = '0;
    block_count_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    error_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 1'b0;
    mdl_head = 0;
    mdl_count = 0;
    mdl_first = '0;
    mdl_next = '0;
    mdl_max_blk = alst_pkg::MAX_BLK_RESET;
    foreach (mdl_start[i]) begin
      mdl_start[i] = '0;
      mdl_len[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_back_pressure();
    test_random_phases();
    test_table_full();
    test_number_space_end();

    drain_results();
    if (error_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
